### design/mlfq_pkg.sv
// Shared constants for the two-runqueue feedback queue scheduler.
// Field widths, register indexes, input kinds and reset values.
// No dependencies.
package mlfq_pkg;

	localparam int THREAD_W = 6;
	localparam int LEVEL_W  = 3;
	localparam int SLICE_W  = 16;
	localparam int CFG_IDX_W = 2;

	localparam int MAX_THREADS_DEF = 64;
	localparam int NUM_LEVELS_DEF  = 8;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_SLICE_TICKS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_LEVEL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOWEST_LEVEL  = 2'd2;

	// Input item kinds.
	localparam logic OP_ENQUEUE = 1'b0;
	localparam logic OP_TICK    = 1'b1;

	localparam logic [SLICE_W-1:0] SLICE_TICKS_RST   = 16'd10;
	localparam logic [LEVEL_W-1:0] DEFAULT_LEVEL_RST = 3'd4;
	localparam logic [LEVEL_W-1:0] LOWEST_LEVEL_RST  = 3'd0;
	localparam logic [SLICE_W-1:0] SLICE_MAX         = 16'hFFFF;

endpackage

### design/mlfq_two_runqueue_scheduler.sv
// Thread scheduler with a multilevel feedback queue, active and expired runqueues and a
// FIFO of just-queued threads. Level queues live in head, tail and next-link memories.
// Depends on mlfq_pkg.
//
// Usage: each input item on the s_ channel is an enqueue (s_tuser = 0, thread id in
// s_tdata) or a timer tick (s_tuser = 1). Every item yields exactly one result item on
// the m_ channel with the running thread, its level, and switch and reject flags.
// Configuration is written through the cfg_ channel, which is always ready; it must only
// be written while no item is in flight.
// An enqueue or a tick that does not end the slice goes from accept to the finishing state,
// which loads the output register. A tick that ends the slice runs a dispatch sequence
// first: each list step is one read of the registered head, tail or next-link memory
// followed by a write, and an empty active queue costs an extra swap and splice pass.
// One item is in the block at a time; a new item is accepted as soon as the previous
// result sits in the output register, even if the receiver has not taken it.
// When the receiver stalls, the finished result of the next item waits inside until the
// output register is free, and input stops.
// Reset: thread 0 runs at the default level, all queues are empty, only thread 0 is
// present, configuration returns to slice 10, default level 4, lowest level 0. The
// queue memories need no clearing since only non-empty queues are read.
module mlfq_two_runqueue_scheduler #(
	parameter int MAX_THREADS = mlfq_pkg::MAX_THREADS_DEF,
	parameter int NUM_LEVELS  = mlfq_pkg::NUM_LEVELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [5:0] thread_id, [7:6] zero
	input  logic [0:0]  s_tuser,   // [0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [5:0] running_thread, [8:6] running_level,
	                               // [9] switched, [10] rejected, [15:11] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [mlfq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int TW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
	localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int NQ = 2 * NUM_LEVELS;
	localparam int QW = $clog2(NQ);
	localparam int IDW = mlfq_pkg::THREAD_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DISP, ST_SEL, ST_SPLICE, ST_FIFO_NX, ST_POP_RD, ST_POP_NX,
		ST_PUSH_RD, ST_PUSH_WR, ST_COMMIT, ST_FIN
	} state_t;

	function automatic logic [LW-1:0] clip_level(input logic [mlfq_pkg::LEVEL_W-1:0] v);
		if (32'(v) > NUM_LEVELS - 1)
			return LW'(NUM_LEVELS - 1);
		return LW'(v);
	endfunction

	function automatic logic [QW-1:0] qidx(input logic sel, input logic [LW-1:0] lvl);
		if (sel)
			return QW'(NUM_LEVELS) + QW'(lvl);
		return QW'(lvl);
	endfunction

	state_t state_q;
	logic [mlfq_pkg::SLICE_W-1:0] slice_ticks_q, slice_used_q;
	logic [mlfq_pkg::LEVEL_W-1:0] default_level_q, lowest_level_q;
	logic [IDW-1:0] run_id_q, nid_q, fifo_head_q, fifo_tail_q;
	logic [LW-1:0] run_prio_q, nlvl_q;
	logic fresh_q, as_q, fifo_ne_q, first_q, sw_q, rej_q;
	logic [NQ-1:0] ne_q;
	logic [MAX_THREADS-1:0] present_q;
	logic [QW-1:0] q_q, push_q_q;
	logic out_valid_q;
	logic [15:0] out_data_q;

	// Memories.
	logic [IDW-1:0] next_link_mem [MAX_THREADS];
	logic [IDW-1:0] head_mem [NQ];
	logic [IDW-1:0] tail_mem [NQ];
	logic nl_we, hd_we, tl_we;
	logic [TW-1:0] nl_wa, nl_ra;
	logic [QW-1:0] hd_wa, hd_ra, tl_wa, tl_ra;
	logic [IDW-1:0] nl_wd, hd_wd, tl_wd, nl_rd, hd_rd, tl_rd;

	always_ff @(posedge clk) begin
		if (nl_we)
			next_link_mem[nl_wa] <= nl_wd;
		nl_rd <= next_link_mem[nl_ra];
	end

	always_ff @(posedge clk) begin
		if (hd_we)
			head_mem[hd_wa] <= hd_wd;
		hd_rd <= head_mem[hd_ra];
	end

	always_ff @(posedge clk) begin
		if (tl_we)
			tail_mem[tl_wa] <= tl_wd;
		tl_rd <= tail_mem[tl_ra];
	end

	// Decode of the current item and derived values.
	logic accept, tid_ok, enq_ok;
	logic [IDW-1:0] tid;
	logic [mlfq_pkg::SLICE_W-1:0] su_next;
	logic [LW-1:0] dl, low, pc, exp_lvl, enc;
	logic found;
	logic [QW-1:0] splice_q, push_q;

	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign tid = s_tdata[IDW-1:0];
	assign tid_ok = (32'(tid) < MAX_THREADS) && !present_q[TW'(tid)];
	assign enq_ok = accept && (s_tuser[0] == mlfq_pkg::OP_ENQUEUE) && tid_ok;
	assign su_next = (slice_used_q == mlfq_pkg::SLICE_MAX) ? slice_used_q
		: slice_used_q + 1'b1;
	assign dl = clip_level(default_level_q);
	assign low = clip_level(lowest_level_q);
	assign pc = run_prio_q;
	assign exp_lvl = (pc > low) ? pc - 1'b1 : low;
	assign splice_q = qidx(!as_q, dl);
	assign push_q = qidx(!as_q, exp_lvl);
	assign cfg_ready = 1'b1;
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

	// Highest non-empty level of the active queue.
	always_comb begin
		found = 1'b0;
		enc = '0;
		for (int l = 0; l < NUM_LEVELS; l++) begin
			if (ne_q[qidx(as_q, LW'(l))]) begin
				found = 1'b1;
				enc = LW'(l);
			end
		end
	end

	always_comb begin
		nl_we = 1'b0;
		nl_wa = '0;
		nl_wd = '0;
		nl_ra = '0;
		hd_we = 1'b0;
		hd_wa = '0;
		hd_wd = '0;
		hd_ra = '0;
		tl_we = 1'b0;
		tl_wa = '0;
		tl_wd = '0;
		tl_ra = '0;
		case (state_q)
			ST_IDLE: begin
				if (enq_ok && fifo_ne_q) begin
					nl_we = 1'b1;
					nl_wa = TW'(fifo_tail_q);
					nl_wd = tid;
				end
			end
			ST_DISP: begin
				nl_ra = TW'(fifo_head_q);
			end
			ST_SEL: begin
				if (found) begin
					hd_ra = qidx(as_q, enc);
					tl_ra = qidx(as_q, enc);
				end else if (first_q && fifo_ne_q) begin
					// After the swap the expired half becomes active.
					if (ne_q[splice_q]) begin
						tl_ra = splice_q;
					end else begin
						hd_we = 1'b1;
						hd_wa = splice_q;
						hd_wd = fifo_head_q;
						tl_we = 1'b1;
						tl_wa = splice_q;
						tl_wd = fifo_tail_q;
					end
				end
			end
			ST_SPLICE: begin
				nl_we = 1'b1;
				nl_wa = TW'(tl_rd);
				nl_wd = fifo_head_q;
				tl_we = 1'b1;
				tl_wa = q_q;
				tl_wd = fifo_tail_q;
			end
			ST_POP_RD: begin
				nl_ra = TW'(hd_rd);
			end
			ST_POP_NX: begin
				hd_we = 1'b1;
				hd_wa = q_q;
				hd_wd = nl_rd;
			end
			ST_PUSH_RD: begin
				if (ne_q[push_q]) begin
					tl_ra = push_q;
				end else begin
					hd_we = 1'b1;
					hd_wa = push_q;
					hd_wd = run_id_q;
					tl_we = 1'b1;
					tl_wa = push_q;
					tl_wd = run_id_q;
				end
			end
			ST_PUSH_WR: begin
				nl_we = 1'b1;
				nl_wa = TW'(tl_rd);
				nl_wd = run_id_q;
				tl_we = 1'b1;
				tl_wa = push_q_q;
				tl_wd = run_id_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slice_ticks_q <= mlfq_pkg::SLICE_TICKS_RST;
			default_level_q <= mlfq_pkg::DEFAULT_LEVEL_RST;
			lowest_level_q <= mlfq_pkg::LOWEST_LEVEL_RST;
			run_id_q <= '0;
			run_prio_q <= clip_level(mlfq_pkg::DEFAULT_LEVEL_RST);
			slice_used_q <= '0;
			fresh_q <= 1'b1;
			as_q <= 1'b0;
			fifo_ne_q <= 1'b0;
			fifo_head_q <= '0;
			fifo_tail_q <= '0;
			nid_q <= '0;
			nlvl_q <= '0;
			q_q <= '0;
			push_q_q <= '0;
			ne_q <= '0;
			present_q <= MAX_THREADS'(1);
			first_q <= 1'b0;
			sw_q <= 1'b0;
			rej_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					mlfq_pkg::CFG_SLICE_TICKS:   slice_ticks_q <= cfg_data;
					mlfq_pkg::CFG_DEFAULT_LEVEL: default_level_q <= cfg_data[2:0];
					mlfq_pkg::CFG_LOWEST_LEVEL:  lowest_level_q <= cfg_data[2:0];
					default: begin
					end
				endcase
			end
			if (state_q == ST_FIN && (!out_valid_q || m_tready))
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						sw_q <= 1'b0;
						rej_q <= (s_tuser[0] == mlfq_pkg::OP_ENQUEUE) && !tid_ok;
						if (s_tuser[0] == mlfq_pkg::OP_ENQUEUE) begin
							state_q <= ST_FIN;
							if (tid_ok) begin
								present_q[TW'(tid)] <= 1'b1;
								if (!fifo_ne_q)
									fifo_head_q <= tid;
								fifo_tail_q <= tid;
								fifo_ne_q <= 1'b1;
							end
						end else begin
							slice_used_q <= su_next;
							if (su_next >= slice_ticks_q)
								state_q <= ST_DISP;
							else
								state_q <= ST_FIN;
						end
					end
				end
				ST_DISP: begin
					if (fresh_q && fifo_ne_q) begin
						fresh_q <= 1'b0;
						nid_q <= fifo_head_q;
						nlvl_q <= dl;
						if (fifo_head_q == fifo_tail_q) begin
							fifo_ne_q <= 1'b0;
							state_q <= ST_PUSH_RD;
						end else begin
							state_q <= ST_FIFO_NX;
						end
					end else begin
						first_q <= 1'b1;
						state_q <= ST_SEL;
					end
				end
				ST_SEL: begin
					if (found) begin
						fresh_q <= 1'b1;
						nlvl_q <= enc;
						q_q <= qidx(as_q, enc);
						state_q <= ST_POP_RD;
					end else if (first_q) begin
						as_q <= !as_q;
						first_q <= 1'b0;
						if (fifo_ne_q) begin
							fifo_ne_q <= 1'b0;
							ne_q[splice_q] <= 1'b1;
							q_q <= splice_q;
							if (ne_q[splice_q])
								state_q <= ST_SPLICE;
						end
					end else begin
						// Nothing to run: the current thread keeps the processor.
						state_q <= ST_FIN;
					end
				end
				ST_SPLICE: begin
					state_q <= ST_SEL;
				end
				ST_FIFO_NX: begin
					fifo_head_q <= nl_rd;
					state_q <= ST_PUSH_RD;
				end
				ST_POP_RD: begin
					nid_q <= hd_rd;
					if (hd_rd == tl_rd) begin
						ne_q[q_q] <= 1'b0;
						state_q <= ST_PUSH_RD;
					end else begin
						state_q <= ST_POP_NX;
					end
				end
				ST_POP_NX: begin
					state_q <= ST_PUSH_RD;
				end
				ST_PUSH_RD: begin
					push_q_q <= push_q;
					if (ne_q[push_q]) begin
						state_q <= ST_PUSH_WR;
					end else begin
						ne_q[push_q] <= 1'b1;
						state_q <= ST_COMMIT;
					end
				end
				ST_PUSH_WR: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					run_id_q <= nid_q;
					run_prio_q <= nlvl_q;
					slice_used_q <= '0;
					sw_q <= 1'b1;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!out_valid_q || m_tready) begin
						out_data_q <= {5'd0, rej_q, sw_q,
							mlfq_pkg::LEVEL_W'(run_prio_q), run_id_q};
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
